/* hdl/arq_rcv_pkg.sv */
// Shared types, codes and constants of the ARQ receiver.
`timescale 1ns / 1ps
package arq_rcv_pkg;

  // Field and register widths
  localparam int SEQ_W    = 4;
  localparam int MODE_W   = 2;
  localparam int SLEN_W   = 5;
  localparam int EXP_W    = 5;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Parameter defaults
  localparam int SEQ_SPACE_DEF = 16;
  localparam int LEN_CAP       = 16;
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RST = 2'd0;
  localparam logic [SLEN_W-1:0] SLEN_RST = 5'd11;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_SW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GBN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SR  = 2'd2;

  // Register select codes (paddr bit 2)
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SLEN = 1'b1;

  // Result kinds
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_DELIV = 1'b1;

  // Active configuration seen by the front and back parts
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [EXP_W-1:0]  len;   // clamped session length
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] number;
    logic             last;
  } res_t;

endpackage

/* hdl/arq_receiver_unit.sv */
// ARQ receiver top level: register port, front filter, back sequencer, result queue.
//
// Usage: push one received sequence number per beat on in_seq_num with push
// while full is low. Results come out as a queue: while empty is low the
// oldest result is on out_kind / out_number / out_last, and pop takes it.
// out_kind is 0 for an acknowledgement and 1 for an in-order delivery;
// out_last marks the final result of one packet. Packets that cause no
// result produce no beat at all.
// A packet waits in the packet queue; its first result is written into the result queue when the sequencer takes it.
// The back sequencer takes each packet together with its ack if any, then
// emits its deliveries one by one and takes no new packet until they are done;
// in selective repeat one packet can give one ack plus up to sixteen deliveries.
// Registers: arq_mode at byte 0x0, session_length at byte 0x4, written by an
// APB setup/access pair; write them only while no packet is in flight.
// Reset (rst_n low, synchronous) empties both queues, clears the expected
// number and marks, and loads arq_mode 0 and session_length 11.
// If pop stays low the result queue fills, the sequencer halts and then the
// packet queue fills and raises full; nothing is lost.
`timescale 1ns / 1ps
module arq_receiver_unit #(
  parameter int SEQ_SPACE = arq_rcv_pkg::SEQ_SPACE_DEF,
  parameter int MID_DEPTH = arq_rcv_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = arq_rcv_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [arq_rcv_pkg::ADDR_W-1:0] paddr,
  input  logic [arq_rcv_pkg::DATA_W-1:0] pwdata,
  output logic [arq_rcv_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  // Packet input
  input  logic                           push,
  output logic                           full,
  input  logic [arq_rcv_pkg::SEQ_W-1:0]  in_seq_num,
  // Results
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_kind,
  output logic [arq_rcv_pkg::SEQ_W-1:0]  out_number,
  output logic                           out_last
);

  localparam int CAP = (SEQ_SPACE < arq_rcv_pkg::LEN_CAP) ? SEQ_SPACE : arq_rcv_pkg::LEN_CAP;
  localparam logic [arq_rcv_pkg::SLEN_W-1:0] CAP_V = arq_rcv_pkg::SLEN_W'(CAP);
  localparam int RES_W = $bits(arq_rcv_pkg::res_t);

  logic [arq_rcv_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [arq_rcv_pkg::SLEN_W-1:0] slen_r, slen_nxt;
  logic                           wr_hit;
  arq_rcv_pkg::cfg_t              cfg;

  logic                           item_pop, item_empty;
  logic [arq_rcv_pkg::SEQ_W-1:0]  item_seq;
  logic                           res_push, res_full;
  arq_rcv_pkg::res_t              res, res_q;
  logic [RES_W-1:0]               res_q_bits;

  // Register writes
  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & pready;

  always_comb begin
    mode_nxt = mode_r;
    slen_nxt = slen_r;
    if (wr_hit) begin
      case (paddr[2])
        arq_rcv_pkg::REG_MODE: mode_nxt = pwdata[arq_rcv_pkg::MODE_W-1:0];
        arq_rcv_pkg::REG_SLEN: slen_nxt = pwdata[arq_rcv_pkg::SLEN_W-1:0];
        default: mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= arq_rcv_pkg::MODE_RST;
      slen_r <= arq_rcv_pkg::SLEN_RST;
    end else begin
      mode_r <= mode_nxt;
      slen_r <= slen_nxt;
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      arq_rcv_pkg::REG_MODE:
        prdata = {{(arq_rcv_pkg::DATA_W - arq_rcv_pkg::MODE_W){1'b0}}, mode_r};
      arq_rcv_pkg::REG_SLEN:
        prdata = {{(arq_rcv_pkg::DATA_W - arq_rcv_pkg::SLEN_W){1'b0}}, slen_r};
      default: prdata = '0;
    endcase
  end

  // Clamp session length to 1..CAP
  always_comb begin
    cfg.mode = mode_r;
    if (slen_r == '0) begin
      cfg.len = arq_rcv_pkg::EXP_W'(1);
    end else if (slen_r > CAP_V) begin
      cfg.len = CAP_V;
    end else begin
      cfg.len = slen_r;
    end
  end

  arq_rcv_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .in_seq_num (in_seq_num),
    .item_pop   (item_pop),
    .item_seq   (item_seq),
    .item_empty (item_empty)
  );

  arq_rcv_back #(
    .MARK_W (CAP)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_empty (item_empty),
    .item_seq   (item_seq),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  arq_rcv_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q_bits),
    .empty   (empty)
  );

  assign res_q      = arq_rcv_pkg::res_t'(res_q_bits);
  assign out_kind   = res_q.kind;
  assign out_number = res_q.number;
  assign out_last   = res_q.last;

endmodule

/* hdl/arq_rcv_fifo.sv */
// Small register-based queue used between the parts of the ARQ receiver.
`timescale 1ns / 1ps
module arq_rcv_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr & ~do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd & ~do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/arq_rcv_front.sv */
// Front part: accepts packets, drops those of the unused mode, queues the rest.
`timescale 1ns / 1ps
module arq_rcv_front #(
  parameter int MID_DEPTH = arq_rcv_pkg::MID_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  arq_rcv_pkg::cfg_t            cfg,
  input  logic                         push,
  output logic                         full,
  input  logic [arq_rcv_pkg::SEQ_W-1:0] in_seq_num,
  input  logic                         item_pop,
  output logic [arq_rcv_pkg::SEQ_W-1:0] item_seq,
  output logic                         item_empty
);

  logic keep;

  // Drop everything in the unused mode; out-of-range packets still go on,
  // since they restart a session left past a shrunk length
  always_comb begin
    keep = 1'b1;
    if (cfg.mode != arq_rcv_pkg::MODE_SW && cfg.mode != arq_rcv_pkg::MODE_GBN &&
        cfg.mode != arq_rcv_pkg::MODE_SR) begin
      keep = 1'b0;
    end
  end

  arq_rcv_fifo #(
    .WIDTH (arq_rcv_pkg::SEQ_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push & keep),
    .wr_data (in_seq_num),
    .full    (full),
    .rd_en   (item_pop),
    .rd_data (item_seq),
    .empty   (item_empty)
  );

endmodule

/* hdl/arq_rcv_back.sv */
// Back part: keeps the expected number and marks, emits acks and deliveries.
`timescale 1ns / 1ps
module arq_rcv_back #(
  parameter int MARK_W = arq_rcv_pkg::LEN_CAP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arq_rcv_pkg::cfg_t             cfg,
  input  logic                          item_empty,
  input  logic [arq_rcv_pkg::SEQ_W-1:0] item_seq,
  output logic                          item_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output arq_rcv_pkg::res_t             res
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DELIV = 1'b1;
  localparam logic [MARK_W-1:0] ONE = {{(MARK_W-1){1'b0}}, 1'b1};

  logic                          st_r, st_nxt;
  logic [arq_rcv_pkg::EXP_W-1:0] expected_r, expected_nxt;
  logic [MARK_W-1:0]             marks_r, marks_nxt;

  logic [arq_rcv_pkg::EXP_W-1:0] exp0, exp_inc, d_inc;
  logic [MARK_W-1:0]             marks0, marks1, seq_bit, marks_clr;
  logic                          stale, hit, below, marked, more, wrap, d_wrap, d_more;
  logic                          in_rng;
  logic [arq_rcv_pkg::EXP_W-1:0] seq_x;

  // Restart a session left at or past the current length
  assign stale   = (expected_r >= cfg.len);
  assign exp0    = stale ? '0 : expected_r;
  assign marks0  = stale ? '0 : marks_r;
  assign seq_x   = {1'b0, item_seq};
  assign in_rng  = (seq_x < cfg.len);
  assign hit     = (seq_x == exp0);
  assign below   = (seq_x < exp0);
  assign exp_inc = exp0 + 1'b1;
  assign wrap    = (exp_inc >= cfg.len);
  assign seq_bit = ONE << item_seq;
  assign marked  = |(marks0 & seq_bit);
  assign marks1  = below ? marks0 : (marks0 | seq_bit);
  assign more    = |(marks1 & (ONE << exp0));

  // Delivery step from the stored expected number
  assign marks_clr = marks_r & ~(ONE << expected_r);
  assign d_inc     = expected_r + 1'b1;
  assign d_wrap    = (d_inc >= cfg.len);
  assign d_more    = |(marks_clr & (ONE << d_inc));

  always_comb begin
    st_nxt       = st_r;
    expected_nxt = expected_r;
    marks_nxt    = marks_r;
    item_pop     = 1'b0;
    res_push     = 1'b0;
    res.kind     = arq_rcv_pkg::KIND_ACK;
    res.number   = item_seq;
    res.last     = 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (!item_empty && !res_full) begin
          item_pop     = 1'b1;
          expected_nxt = exp0;
          marks_nxt    = marks0;
          // Out-of-range packets only restart a stale session
          if (in_rng) begin
            case (cfg.mode)
              arq_rcv_pkg::MODE_SW,
              arq_rcv_pkg::MODE_GBN: begin
                // Ack every packet in stop-and-wait, only in-order ones in go-back-N
                res_push = hit | (cfg.mode == arq_rcv_pkg::MODE_SW);
                if (hit) begin
                  if (wrap) begin
                    expected_nxt = '0;
                    marks_nxt    = '0;
                  end else begin
                    expected_nxt = exp_inc;
                  end
                end
              end
              arq_rcv_pkg::MODE_SR: begin
                // Mark new packets, re-ack old ones, then drain in-order marks
                res_push  = below | ~marked;
                res.last  = ~more;
                marks_nxt = marks1;
                if (more) begin
                  st_nxt = ST_DELIV;
                end
              end
              default: begin
                res_push = 1'b0;
              end
            endcase
          end
        end
      end
      ST_DELIV: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.kind   = arq_rcv_pkg::KIND_DELIV;
          res.number = expected_r[arq_rcv_pkg::SEQ_W-1:0];
          if (d_wrap) begin
            expected_nxt = '0;
            marks_nxt    = '0;
            res.last     = 1'b1;
            st_nxt       = ST_IDLE;
          end else begin
            expected_nxt = d_inc;
            marks_nxt    = marks_clr;
            res.last     = ~d_more;
            if (!d_more) begin
              st_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      expected_r <= '0;
      marks_r    <= '0;
    end else begin
      st_r       <= st_nxt;
      expected_r <= expected_nxt;
      marks_r    <= marks_nxt;
    end
  end

endmodule
